// File: rtl/core/jet_quality_classifier_core_macros.svh
// Assertion macros shared by the jet quality classifier RTL.
`ifndef JET_QUALITY_CLASSIFIER_CORE_MACROS_SVH
`define JET_QUALITY_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define JQC_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("jet quality classifier: assertion failed");

// Next-cycle implication, disabled during reset
`define JQC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("jet quality classifier: assertion failed");

`endif

// File: rtl/core/jqc_pkg.sv
// Package: widths, codes, cut thresholds and fraction compare helpers for the jet classifier.
package jqc_pkg;

  // Port and datapath widths
  localparam int ENERGY_W    = 24;
  localparam int ENERGY_BITS = 24;
  localparam int ETA_W       = 14;
  localparam int COUNT_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;
  localparam int PCT_W       = 7;
  localparam int PROD_W      = ENERGY_BITS + PCT_W;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_YEAR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KIND = 2'd1;

  typedef enum logic [1:0] {
    YEAR_2016,
    YEAR_2017,
    YEAR_2018,
    YEAR_UNUSED
  } year_t;

  typedef enum logic {
    KIND_CHS,
    KIND_PUPPI
  } kind_t;

  // Region bounds on |eta| in thousandths
  localparam logic [ETA_W-1:0] ETA_2P4 = 14'd2400;
  localparam logic [ETA_W-1:0] ETA_2P6 = 14'd2600;
  localparam logic [ETA_W-1:0] ETA_2P7 = 14'd2700;
  localparam logic [ETA_W-1:0] ETA_3P0 = 14'd3000;

  // Fraction thresholds in hundredths
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [PCT_W-1:0] PCT_99    = 7'd99;
  localparam logic [PCT_W-1:0] PCT_98    = 7'd98;
  localparam logic [PCT_W-1:0] PCT_90    = 7'd90;
  localparam logic [PCT_W-1:0] PCT_80    = 7'd80;
  localparam logic [PCT_W-1:0] PCT_20    = 7'd20;
  localparam logic [PCT_W-1:0] PCT_02    = 7'd2;
  localparam logic [PCT_W-1:0] PCT_01    = 7'd1;

  // Constituent count thresholds
  localparam logic [COUNT_W-1:0] NM_MIN_MID = 8'd2;
  localparam logic [COUNT_W-1:0] NM_MIN_FWD = 8'd10;
  localparam logic [COUNT_W-1:0] NM_MAX_FWD = 8'd15;
  localparam logic [COUNT_W:0]   NCONST_MIN = 9'd1;

  // Fraction x/e strictly below c/100, false for zero energy
  function automatic logic frac_lt(input logic [ENERGY_BITS-1:0] x,
                                   input logic [ENERGY_BITS-1:0] e,
                                   input logic [PCT_W-1:0] c);
    logic [PROD_W-1:0] xs;
    logic [PROD_W-1:0] es;
    xs = PROD_W'(x) * PROD_W'(PCT_SCALE);
    es = PROD_W'(e) * PROD_W'(c);
    return (e != '0) && (xs < es);
  endfunction

  // Fraction x/e strictly above c/100, false for zero energy
  function automatic logic frac_gt(input logic [ENERGY_BITS-1:0] x,
                                   input logic [ENERGY_BITS-1:0] e,
                                   input logic [PCT_W-1:0] c);
    logic [PROD_W-1:0] xs;
    logic [PROD_W-1:0] es;
    xs = PROD_W'(x) * PROD_W'(PCT_SCALE);
    es = PROD_W'(e) * PROD_W'(c);
    return (e != '0) && (xs > es);
  endfunction

endpackage

// File: rtl/core/jet_quality_classifier_core.sv
// Jet quality classifier: jet ID and lepton veto decisions, one jet per cycle.
//
// Usage:
//   Input channel: a jet is transferred on a rising edge with start high and
//   busy low. busy is low at all times except while rst is high, so a new jet
//   may be offered in every cycle.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   Index 0 sets the year rule set, index 1 the jet kind; other indexes are
//   ignored. Write only while no jet is in flight.
//   Result channel: result_valid strobes for one cycle with loose_pass,
//   tight_pass and lepton_veto_pass. The receiver cannot stall the block.
//   Path: each jet passes the input register, then the result register.
//   Throughput: one jet per cycle, set by the single compare stage between
//   the two registers.
//   Reset: rst clears the pipeline valid bits and both configuration
//   registers (2016 rules, charged-hadron-subtracted jets).
`include "jet_quality_classifier_core_macros.svh"

module jet_quality_classifier_core import jqc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [ETA_W-1:0]       eta_milli,
  input  logic [ENERGY_W-1:0]    total_energy,
  input  logic [ENERGY_W-1:0]    neutral_hadron_energy,
  input  logic [ENERGY_W-1:0]    neutral_em_energy,
  input  logic [ENERGY_W-1:0]    charged_hadron_energy,
  input  logic [ENERGY_W-1:0]    charged_em_energy,
  input  logic [ENERGY_W-1:0]    muon_energy,
  input  logic [COUNT_W-1:0]     charged_count,
  input  logic [COUNT_W-1:0]     neutral_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   result_valid,
  output logic                   loose_pass,
  output logic                   tight_pass,
  output logic                   lepton_veto_pass
);

  // Configuration registers
  year_t year;
  kind_t kind;

  // Input register stage
  logic                   in_valid;
  logic [ETA_W-1:0]       eta_raw;
  logic [ENERGY_BITS-1:0] e;
  logic [ENERGY_BITS-1:0] nh;
  logic [ENERGY_BITS-1:0] nem;
  logic [ENERGY_BITS-1:0] ch;
  logic [ENERGY_BITS-1:0] cem;
  logic [ENERGY_BITS-1:0] mu;
  logic [COUNT_W-1:0]     cm;
  logic [COUNT_W-1:0]     nm;

  // Decision logic
  logic [ETA_W-1:0]   eta_abs;
  logic [COUNT_W:0]   nconst;
  logic               chf_pos;
  logic               central, upto26, upto27, mid, fwd;
  logic               nh_lt99, nh_lt98, nh_lt90, nh_gt02, nh_gt20;
  logic               nem_lt99, nem_lt90, nem_gt01, nem_gt02;
  logic               cem_lt99, mu_lt80;
  logic               track16, fwd_mid16, fwd_far16;
  logic               track17, core17;
  logic               core18, edge18;
  logic               loose_next, tight_next, veto_next;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      year <= YEAR_2016;
      kind <= KIND_CHS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_YEAR: year <= year_t'(cfg_data);
        CFG_KIND: kind <= kind_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // Capture a jet on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      eta_raw <= eta_milli;
      e       <= total_energy[ENERGY_BITS-1:0];
      nh      <= neutral_hadron_energy[ENERGY_BITS-1:0];
      nem     <= neutral_em_energy[ENERGY_BITS-1:0];
      ch      <= charged_hadron_energy[ENERGY_BITS-1:0];
      cem     <= charged_em_energy[ENERGY_BITS-1:0];
      mu      <= muon_energy[ENERGY_BITS-1:0];
      cm      <= charged_count;
      nm      <= neutral_count;
    end
  end

  // Eta magnitude, regions and energy fraction compares
  always_comb begin
    eta_abs = eta_raw[ETA_W-1] ? ETA_W'(~eta_raw + 1'b1) : eta_raw;
    nconst  = {1'b0, cm} + {1'b0, nm};
    chf_pos = (e != '0) && (ch != '0);
    central = eta_abs <= ETA_2P4;
    upto26  = eta_abs <= ETA_2P6;
    upto27  = eta_abs <= ETA_2P7;
    mid     = (eta_abs > ETA_2P7) && (eta_abs <= ETA_3P0);
    fwd     = eta_abs > ETA_3P0;

    nh_lt99  = frac_lt(nh, e, PCT_99);
    nh_lt98  = frac_lt(nh, e, PCT_98);
    nh_lt90  = frac_lt(nh, e, PCT_90);
    nh_gt02  = frac_gt(nh, e, PCT_02);
    nh_gt20  = frac_gt(nh, e, PCT_20);
    nem_lt99 = frac_lt(nem, e, PCT_99);
    nem_lt90 = frac_lt(nem, e, PCT_90);
    nem_gt01 = frac_gt(nem, e, PCT_01);
    nem_gt02 = frac_gt(nem, e, PCT_02);
    cem_lt99 = frac_lt(cem, e, PCT_99);
    mu_lt80  = frac_lt(mu, e, PCT_80);
  end

  // Combine the cuts of the selected rule set
  always_comb begin
    track16   = (central && chf_pos && (cm != '0) && cem_lt99) || !central;
    fwd_mid16 = nh_lt98 && nem_gt01 && (nm > NM_MIN_MID) && mid;
    fwd_far16 = nem_lt90 && (nm > NM_MIN_FWD) && fwd;
    track17   = (central && chf_pos && (cm != '0)) || !central;
    core17    = nh_lt90 && nem_lt90 && (nconst > NCONST_MIN) && track17 && upto27;
    core18    = (cm != '0) && chf_pos && (nconst > NCONST_MIN) && nem_lt90 && nh_lt90
                && upto26;
    edge18    = nem_lt99 && nh_lt90 && !upto26 && upto27;

    loose_next = 1'b1;
    tight_next = 1'b1;
    case (year)
      YEAR_2016: begin
        loose_next = (nh_lt99 && nem_lt99 && (nconst > NCONST_MIN) && track16 && upto27)
                     || fwd_mid16 || fwd_far16;
        tight_next = (nh_lt90 && nem_lt90 && (nconst > NCONST_MIN) && track16 && upto27)
                     || fwd_mid16 || fwd_far16;
      end
      YEAR_2017: begin
        if (kind == KIND_CHS) begin
          tight_next = core17
                       || (nem_lt99 && nem_gt02 && (nm > NM_MIN_MID) && mid)
                       || (nem_lt90 && nh_gt02 && (nm > NM_MIN_FWD) && fwd);
        end else begin
          tight_next = core17
                       || (nh_lt99 && mid)
                       || (nem_lt90 && nh_gt02 && (nm < NM_MAX_FWD) && (nm > NM_MIN_MID)
                           && fwd);
        end
      end
      YEAR_2018: begin
        if (kind == KIND_CHS) begin
          tight_next = core18
                       || ((cm != '0) && edge18)
                       || (nem_gt02 && nem_lt99 && (nm > NM_MIN_MID) && mid)
                       || (nem_lt90 && nh_gt20 && (nm > NM_MIN_FWD) && fwd);
        end else begin
          tight_next = core18
                       || edge18
                       || (nh_lt99 && mid)
                       || (nem_lt90 && nh_gt02 && (nm > NM_MIN_MID) && (nm < NM_MAX_FWD)
                           && fwd);
        end
      end
      default: begin
        loose_next = 1'b1;
        tight_next = 1'b1;
      end
    endcase

    veto_next = (mu_lt80 && upto27) || !upto27;
  end

  // Result register: strobe one cycle per jet
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      loose_pass       <= loose_next;
      tight_pass       <= tight_next;
      lepton_veto_pass <= veto_next;
    end
  end

  // Checks on the pipeline and the decision rules
  `JQC_ASSERT_NEXT(a_accept_fills_stage, clk, rst, start && !busy, in_valid)
  `JQC_ASSERT_NEXT(a_stage_gives_result, clk, rst, in_valid, result_valid)
  `JQC_ASSERT_NEXT(a_loose_late_years, clk, rst,
                   in_valid && (year == YEAR_2017 || year == YEAR_2018), loose_pass)
  `JQC_ASSERT_NEXT(a_zero_energy_central_veto, clk, rst,
                   in_valid && (e == '0) && upto27, !lepton_veto_pass)
  `JQC_ASSERT_NEXT(a_forward_veto_passes, clk, rst, in_valid && !upto27, lepton_veto_pass)

endmodule
